### hw/rtl/b2da_pkg.sv
package b2da_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam logic [5:0] ASCII_ZERO = 6'd48;

	// decimal digit count of the largest w-bit number, floor(w * log10 2) + 1
	function automatic int num_digits(input int w);
		num_digits = (w * 30103) / 100000 + 1;
	endfunction

	typedef struct packed {
		logic load;
		logic conv;
		logic shift;
	} cell_ctrl_t;

endpackage

### hw/rtl/binary_to_decimal_ascii.sv
// channel | signals                          | word
// input   | in_valid / in_ready              | value
// output  | out_valid / out_ready            | digit_char, last
//
// a word is loaded, then run through the chain of digit cells by double
// dabble, one shift per value bit, then each decimal digit position is
// stepped out from the top cell (leading zeros are stepped past without
// output). in_ready is high only while idle. a stalled output holds the
// digit chain still. arst_n clears the sequencer and output valid.
module binary_to_decimal_ascii #(
	parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [VALUE_WIDTH-1:0] value,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [5:0]             digit_char,
	output logic                   last
);
	import b2da_pkg::*;

	localparam int NDIG = num_digits(VALUE_WIDTH);
	localparam int BW   = $clog2(VALUE_WIDTH + 1);
	localparam int DW   = $clog2(NDIG + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]             state_q;
	logic [VALUE_WIDTH-1:0] sr_q;
	logic [BW-1:0]          bit_cnt_q;
	logic [DW-1:0]          dig_cnt_q;
	logic                   seen_q;
	logic                   out_valid_q;
	logic [5:0]             digit_q;
	logic                   last_q;

	cell_ctrl_t ctrl;
	logic [NDIG:0]   carry;
	logic [3:0]      digits [NDIG];
	logic [3:0]      top;
	logic            step;
	logic            emit_now;

	assign carry[0] = sr_q[VALUE_WIDTH-1];

	for (genvar i = 0; i < NDIG; i++) begin : g_cell
		logic [3:0] din;
		if (i == 0) begin : g_first
			assign din = 4'd0;
		end else begin : g_rest
			assign din = digits[i-1];
		end
		b2da_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.carry_in  (carry[i]),
			.digit_in  (din),
			.carry_out (carry[i+1]),
			.digit_q   (digits[i])
		);
	end

	assign top      = digits[NDIG-1];
	assign step     = !out_valid_q || out_ready;
	assign emit_now = (top != 4'd0) || seen_q || (dig_cnt_q == DW'(1));

	always_comb begin
		ctrl.load  = (state_q == ST_IDLE) && in_valid;
		ctrl.conv  = (state_q == ST_CONV);
		ctrl.shift = (state_q == ST_EMIT) && step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.shift && emit_now) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					if (bit_cnt_q == BW'(1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (step) begin
						if (dig_cnt_q == DW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				sr_q      <= value;
				bit_cnt_q <= BW'(VALUE_WIDTH);
			end
			ST_CONV: begin
				sr_q      <= {sr_q[VALUE_WIDTH-2:0], 1'b0};
				bit_cnt_q <= bit_cnt_q - BW'(1);
				dig_cnt_q <= DW'(NDIG);
				seen_q    <= 1'b0;
			end
			ST_EMIT: begin
				if (step) begin
					dig_cnt_q <= dig_cnt_q - DW'(1);
					if (emit_now) begin
						seen_q  <= 1'b1;
						digit_q <= ASCII_ZERO | {2'b00, top};
						last_q  <= (dig_cnt_q == DW'(1));
					end
				end
			end
			default: begin
				seen_q <= 1'b0;
			end
		endcase
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign digit_char = digit_q;
	assign last       = last_q;

endmodule

### hw/rtl/b2da_cell.sv
module b2da_cell (
	input  logic                  clk,
	input  b2da_pkg::cell_ctrl_t  ctrl,
	input  logic                  carry_in,
	input  logic [3:0]            digit_in,
	output logic                  carry_out,
	output logic [3:0]            digit_q
);
	import b2da_pkg::*;

	logic [3:0] corr;

	// add three before the doubling so the digit stays decimal
	assign corr      = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	assign carry_out = corr[3];

	always_ff @(posedge clk) begin
		priority if (ctrl.load) begin
			digit_q <= 4'd0;
		end else if (ctrl.conv) begin
			digit_q <= {corr[2:0], carry_in};
		end else if (ctrl.shift) begin
			digit_q <= digit_in;
		end else begin
			digit_q <= digit_q;
		end
	end

endmodule

### hw/rtl/b2da_checker.sv
module b2da_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [5:0] digit_char,
	input logic       last
);

	// a word starts a conversion, so the input closes next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready straight after accepting a word");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (digit_char >= 6'd48) && (digit_char <= 6'd57))
		else $error("output character is not a decimal digit");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped before acceptance");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(digit_char) && $stable(last))
		else $error("stalled output word changed");

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.digit_char (digit_char),
	.last       (last)
);
